// ===== rtl/core/sliding_window_flow_retransmit_control_core_macros.svh =====
// assertion macros for the sliding window flow core checker
// needs clk and rst_n in the scope of use
`ifndef SLIDING_WINDOW_FLOW_RETRANSMIT_CONTROL_CORE_MACROS_SVH
`define SLIDING_WINDOW_FLOW_RETRANSMIT_CONTROL_CORE_MACROS_SVH

// same-cycle implication
`define SWFRC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SWFRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/swfrc_pkg.sv =====
`timescale 1ns / 1ps
// shared types, codes and helpers for the sliding window flow core
// no dependencies
package swfrc_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int QW          = $clog2(QUEUE_DEPTH);
  localparam int HANDLE_BITS = 16;
  localparam logic [31:0] QD32 = 32'(QUEUE_DEPTH);

  localparam int CFG_W     = 40;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ACK_DELAY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEND_INACT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECV_INACT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RTX_EN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_WIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RTO_FLOOR  = 3'd5;

  localparam logic [1:0] CMD_RECEIVE = 2'd0;
  localparam logic [1:0] CMD_SEND    = 2'd1;
  localparam logic [1:0] CMD_DEQUEUE = 2'd2;

  localparam logic [3:0] ST_QUEUED    = 4'd0;
  localparam logic [3:0] ST_NO_RUN    = 4'd1;
  localparam logic [3:0] ST_RDV       = 4'd2;
  localparam logic [3:0] ST_CTRL_ONLY = 4'd3;
  localparam logic [3:0] ST_OLD_DUP   = 4'd4;
  localparam logic [3:0] ST_OUT_WIN   = 4'd5;
  localparam logic [3:0] ST_OUT_QUEUE = 4'd6;
  localparam logic [3:0] ST_QUEUE_DUP = 4'd7;
  localparam logic [3:0] ST_SENT      = 4'd8;
  localparam logic [3:0] ST_DEQUEUED  = 4'd9;
  localparam logic [3:0] ST_EMPTY     = 4'd10;

  // flag bit positions
  localparam int FB_DATA = 0;
  localparam int FB_RUN  = 1;
  localparam int FB_ACK  = 2;
  localparam int FB_WIN  = 3;
  localparam int FB_RDV  = 4;

  localparam logic [6:0] FL_DATA    = 7'h01;
  localparam logic [6:0] FL_RUN     = 7'h02;
  localparam logic [6:0] FL_ACK     = 7'h04;
  localparam logic [6:0] FL_WIN     = 7'h08;
  localparam logic [6:0] FL_ACK_WIN = 7'h0C;

  localparam logic [31:0] WIN_HI_MASK = 32'hFF000000;
  localparam logic [31:0] WIN_HALF    = 32'h007FFFFF;
  localparam logic [31:0] WIN_CARRY   = 32'h01000000;

  localparam logic [47:0] M48      = 48'hFFFF_FFFF_FFFF;
  localparam logic [29:0] NS_PER_S = 30'd1000000000;
  localparam logic [47:0] SRTT_MIN = 48'd1000;
  localparam logic [47:0] DEV_MIN  = 48'd100;

  localparam logic [39:0] RST_ACK_DELAY  = 40'd10000000000;
  localparam logic [15:0] RST_SEND_INACT = 16'd41;
  localparam logic [15:0] RST_RECV_INACT = 16'd31;
  localparam logic [23:0] RST_START_WIN  = 24'd256;
  localparam logic [31:0] RST_RTO_FLOOR  = 32'd250000;
  localparam logic [47:0] RST_DEV        = 48'd10000000;
  localparam logic [47:0] RST_RTO        = 48'd1000000000;

  typedef struct packed {
    logic capture;
    logic load;
    logic prep;
    logic rtt1;
    logic rtt2;
    logic rtt3;
    logic rtt4;
    logic exec;
  } swfrc_cmd_t;

  typedef struct packed {
    logic cmd_known;
    logic rtt_go;
  } swfrc_sts_t;

  // serial number compare: a before b
  function automatic logic seq_before(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

endpackage

// ===== rtl/core/swfrc_ctrl.sv =====
`timescale 1ns / 1ps
// sequencer for the sliding window flow core
// depends on swfrc_pkg
module swfrc_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  output logic                   out_valid,
  input  swfrc_pkg::swfrc_sts_t  sts_i,
  output swfrc_pkg::swfrc_cmd_t  cmd_o
);
  import swfrc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_RTT1 = 3'd3;
  localparam logic [2:0] S_RTT2 = 3'd4;
  localparam logic [2:0] S_RTT3 = 3'd5;
  localparam logic [2:0] S_RTT4 = 3'd6;
  localparam logic [2:0] S_EXEC = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       valid_r, valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_nxt     = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_nxt  = sts_i.cmd_known ? S_PREP : S_IDLE;
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_nxt  = sts_i.rtt_go ? S_RTT1 : S_EXEC;
      end
      S_RTT1: begin
        cmd_o.rtt1 = 1'b1;
        state_nxt  = S_RTT2;
      end
      S_RTT2: begin
        cmd_o.rtt2 = 1'b1;
        state_nxt  = S_RTT3;
      end
      S_RTT3: begin
        cmd_o.rtt3 = 1'b1;
        state_nxt  = S_RTT4;
      end
      S_RTT4: begin
        cmd_o.rtt4 = 1'b1;
        state_nxt  = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    valid_nxt = cmd_o.exec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = valid_r;

endmodule

// ===== rtl/core/swfrc_dp.sv =====
`timescale 1ns / 1ps
// flow state, reorder queue, rtt estimator and result registers
// depends on swfrc_pkg, driven by swfrc_ctrl
module swfrc_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  swfrc_pkg::swfrc_cmd_t               cmd_i,
  output swfrc_pkg::swfrc_sts_t               sts_o,
  input  logic                                cfg_we,
  input  logic [swfrc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [swfrc_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic [1:0]                          in_command,
  input  logic [31:0]                         in_now_sec,
  input  logic [62:0]                         in_now_ns,
  input  logic [6:0]                          in_pkt_flags,
  input  logic [31:0]                         in_pkt_seqno,
  input  logic [31:0]                         in_pkt_ackno,
  input  logic [23:0]                         in_pkt_window,
  input  logic [swfrc_pkg::HANDLE_BITS-1:0]   in_buffer_handle,
  input  logic [31:0]                         in_random_seed,
  output logic [3:0]                          out_status,
  output logic [6:0]                          out_ctrl_flags,
  output logic [31:0]                         out_ctrl_seqno,
  output logic [31:0]                         out_ctrl_ackno,
  output logic [23:0]                         out_ctrl_window,
  output logic [swfrc_pkg::HANDLE_BITS-1:0]   out_handle,
  output logic                                out_arm_ack_timer,
  output logic                                out_arm_retransmit,
  output logic                                out_window_reopened
);
  import swfrc_pkg::*;

  // configuration
  logic [39:0] ack_delay_r;
  logic [15:0] send_inact_r, recv_inact_r;
  logic        rtx_en_r;
  logic [23:0] start_win_r;
  logic [31:0] rto_floor_r;

  // captured item
  logic [1:0]             cmd_q_r;
  logic [31:0]            sec_q_r;
  logic [62:0]            ns_q_r;
  logic [6:0]             flags_q_r;
  logic [31:0]            seq_q_r, ack_q_r, seed_q_r;
  logic [23:0]            win_q_r;
  logic [HANDLE_BITS-1:0] handle_q_r;

  // flow state
  logic [31:0] sle_r, sle_nxt, sre_r, sre_nxt, snext_r, snext_nxt;
  logic [32:0] snd_act_r, snd_act_nxt;
  logic [31:0] rle_r, rle_nxt, rre_r, rre_nxt, rla_r, rla_nxt;
  logic [32:0] rcv_sec_r, rcv_sec_nxt;
  logic [62:0] rcv_ns_r, rcv_ns_nxt;
  logic [47:0] srtt_r, dev_r, rto_r, rto_nxt;
  logic [31:0] probe_seq_r, probe_seq_nxt;
  logic [62:0] probe_ns_r, probe_ns_nxt;
  logic        probe_act_r, probe_act_nxt, win_open_r, win_open_nxt;

  // reorder queue
  logic [QUEUE_DEPTH-1:0] valid_r;
  logic                   valid_q_r;
  logic [HANDLE_BITS-1:0] mem [QUEUE_DEPTH];
  logic [HANDLE_BITS-1:0] mem_q_r;
  logic [QW-1:0]          rd_addr, rx_pos, dq_pos;
  logic                   queue_wr, deq_clr;

  // prepared terms
  logic signed [32:0] rsince, ssince, rsince_r;
  logic               rnever_r, rstale_r, rfresh_r, sstale_r;
  logic signed [63:0] ns_gap_r, probe_gap_r, prod_r;
  logic               rtt_go, rtt_go_r;

  // estimator
  logic [47:0]        mrtt_r;
  logic               first_r;
  logic signed [49:0] d_v, s_new, s_val, ad_v, ad_r, e_r, v_val;
  logic [50:0]        sum_v;
  logic [47:0]        sum_r;

  // execute terms
  logic        run_new, no_run, drop, old_dup, want_ack, rack_ok, ack_time_ok;
  logic [31:0] left_e, right_e, win_cat, win_new, s_base, sle_base, sre_base;
  logic [6:0]  sflags;

  // result next values
  logic [3:0]             st_nxt;
  logic [6:0]             fl_nxt;
  logic [31:0]            sq_nxt, ak_nxt;
  logic [23:0]            wn_nxt;
  logic [HANDLE_BITS-1:0] hd_nxt;
  logic                   aat_nxt, art_nxt, reo_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_delay_r  <= RST_ACK_DELAY;
      send_inact_r <= RST_SEND_INACT;
      recv_inact_r <= RST_RECV_INACT;
      rtx_en_r     <= 1'b1;
      start_win_r  <= RST_START_WIN;
      rto_floor_r  <= RST_RTO_FLOOR;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACK_DELAY:  ack_delay_r  <= cfg_wdata[39:0];
        REG_SEND_INACT: send_inact_r <= cfg_wdata[15:0];
        REG_RECV_INACT: recv_inact_r <= cfg_wdata[15:0];
        REG_RTX_EN:     rtx_en_r     <= cfg_wdata[0];
        REG_START_WIN:  start_win_r  <= cfg_wdata[23:0];
        REG_RTO_FLOOR:  rto_floor_r  <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      cmd_q_r    <= in_command;
      sec_q_r    <= in_now_sec;
      ns_q_r     <= in_now_ns;
      flags_q_r  <= in_pkt_flags;
      seq_q_r    <= in_pkt_seqno;
      ack_q_r    <= in_pkt_ackno;
      win_q_r    <= in_pkt_window;
      handle_q_r <= in_buffer_handle;
      seed_q_r   <= in_random_seed;
    end
  end

  // load: time differences and queue read
  assign rsince  = $signed({1'b0, sec_q_r}) - $signed({1'b0, rcv_sec_r[31:0]});
  assign ssince  = $signed({1'b0, sec_q_r}) - $signed({1'b0, snd_act_r[31:0]});
  assign rx_pos  = seq_q_r[QW-1:0];
  assign dq_pos  = rle_r[QW-1:0];
  assign rd_addr = (cmd_q_r == CMD_DEQUEUE) ? dq_pos : rx_pos;

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      rsince_r    <= rsince;
      rnever_r    <= rcv_sec_r[32];
      rstale_r    <= rcv_sec_r[32] || (rsince > $signed({17'b0, recv_inact_r}));
      rfresh_r    <= !rcv_sec_r[32] && (rsince < $signed({17'b0, recv_inact_r}));
      sstale_r    <= snd_act_r[32] || (ssince > $signed({17'b0, send_inact_r}));
      ns_gap_r    <= $signed({1'b0, ns_q_r}) - $signed({1'b0, rcv_ns_r});
      probe_gap_r <= $signed({1'b0, ns_q_r}) - $signed({1'b0, probe_ns_r});
      mem_q_r     <= mem[rd_addr];
      valid_q_r   <= valid_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (queue_wr) begin
      mem[rx_pos] <= handle_q_r;
    end
  end

  assign rtt_go = (cmd_q_r == CMD_RECEIVE) && !(rstale_r && !flags_q_r[FB_RUN]) &&
                  !flags_q_r[FB_RDV] && flags_q_r[FB_ACK] && probe_act_r &&
                  seq_before(probe_seq_r, ack_q_r);

  assign sts_o.cmd_known = (cmd_q_r == CMD_RECEIVE) || (cmd_q_r == CMD_SEND) ||
                           (cmd_q_r == CMD_DEQUEUE);
  assign sts_o.rtt_go    = rtt_go;

  // prep: scaled seconds and clamped rtt sample
  always_ff @(posedge clk) begin
    if (cmd_i.prep) begin
      prod_r   <= rsince_r * $signed({1'b0, NS_PER_S});
      rtt_go_r <= rtt_go;
      if (probe_gap_r[63]) begin
        mrtt_r <= '0;
      end else if (|probe_gap_r[62:48]) begin
        mrtt_r <= M48;
      end else begin
        mrtt_r <= probe_gap_r[47:0];
      end
    end
  end

  // estimator steps
  assign d_v   = $signed({2'b0, mrtt_r}) - $signed({2'b0, srtt_r});
  assign s_new = $signed({2'b0, srtt_r}) + (d_v >>> 3);
  assign s_val = (srtt_r == '0) ? $signed({2'b0, mrtt_r}) : s_new;
  assign ad_v  = d_v[49] ? -d_v : d_v;
  assign v_val = first_r ? $signed({3'b0, mrtt_r[47:1]}) : $signed({2'b0, dev_r}) + (e_r >>> 2);
  assign sum_v = {3'b0, srtt_r} + {1'b0, dev_r, 2'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srtt_r <= '0;
      dev_r  <= RST_DEV;
    end else begin
      if (cmd_i.rtt1) begin
        srtt_r <= (s_val < $signed({2'b0, SRTT_MIN})) ? SRTT_MIN : s_val[47:0];
      end
      if (cmd_i.rtt3) begin
        dev_r <= (v_val < $signed({2'b0, DEV_MIN})) ? DEV_MIN : v_val[47:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.rtt1) begin
      first_r <= (srtt_r == '0);
      ad_r    <= ad_v;
    end
    if (cmd_i.rtt2) begin
      e_r <= ad_r - $signed({2'b0, dev_r});
    end
    if (cmd_i.rtt4) begin
      sum_r <= (|sum_v[50:48]) ? M48 : sum_v[47:0];
    end
  end

  // execute
  assign run_new  = rstale_r && flags_q_r[FB_RUN];
  assign no_run   = rstale_r && !flags_q_r[FB_RUN];
  assign left_e   = run_new ? seq_q_r : rle_r;
  assign right_e  = run_new ? seq_q_r + QD32 : rre_r;
  assign win_cat  = {8'b0, win_q_r} | (sre_r & WIN_HI_MASK);
  assign win_new  = (seq_before(win_cat, sre_r) && ((sre_r - win_cat) > WIN_HALF)) ?
                    win_cat + WIN_CARRY : win_cat;
  assign ack_time_ok = !rnever_r && !(ns_gap_r > $signed({24'b0, ack_delay_r})) &&
                       !(ns_gap_r < $signed({16'b0, dev_r}));
  assign rack_ok  = !rnever_r && (prod_r <= $signed({24'b0, ack_delay_r}));
  assign s_base   = sstale_r ? seed_q_r : snext_r;
  assign sle_base = sstale_r ? seed_q_r : sle_r;
  assign sre_base = sstale_r ? seed_q_r + {8'b0, start_win_r} : sre_r;

  always_comb begin
    sle_nxt = sle_r;  sre_nxt = sre_r;  snext_nxt = snext_r;  snd_act_nxt = snd_act_r;
    rle_nxt = rle_r;  rre_nxt = rre_r;  rla_nxt = rla_r;
    rcv_sec_nxt = rcv_sec_r;  rcv_ns_nxt = rcv_ns_r;  rto_nxt = rto_r;
    probe_seq_nxt = probe_seq_r;  probe_ns_nxt = probe_ns_r;
    probe_act_nxt = probe_act_r;  win_open_nxt = win_open_r;
    st_nxt = ST_EMPTY;  fl_nxt = '0;  sq_nxt = '0;  ak_nxt = '0;  wn_nxt = '0;
    hd_nxt = '0;  aat_nxt = 1'b0;  art_nxt = 1'b0;  reo_nxt = 1'b0;
    queue_wr = 1'b0;  deq_clr = 1'b0;  drop = 1'b0;  old_dup = 1'b0;
    want_ack = 1'b0;  sflags = FL_DATA;
    if (cmd_i.exec) begin
      if (rtt_go_r) begin
        rto_nxt = (sum_r < {16'b0, rto_floor_r}) ? {16'b0, rto_floor_r} : sum_r;
      end
      case (cmd_q_r)
        CMD_RECEIVE: begin
          rle_nxt = left_e;
          rre_nxt = right_e;
          if (no_run) begin
            st_nxt = ST_NO_RUN;
            drop   = 1'b1;
          end else if (flags_q_r[FB_RDV]) begin
            st_nxt = ST_RDV;
            fl_nxt = FL_WIN;
            wn_nxt = right_e[23:0];
          end else begin
            if (flags_q_r[FB_ACK]) begin
              if (seq_before(sle_r, ack_q_r)) sle_nxt = ack_q_r;
              if (rtt_go_r) probe_act_nxt = 1'b0;
            end
            if (flags_q_r[FB_WIN]) begin
              sre_nxt = win_new;
              if (!win_open_r) begin
                win_open_nxt = 1'b1;
                reo_nxt      = 1'b1;
              end
            end
            if (!flags_q_r[FB_DATA]) begin
              st_nxt = ST_CTRL_ONLY;
              drop   = 1'b1;
            end else if (seq_before(seq_q_r, left_e)) begin
              rla_nxt = seq_q_r;
              old_dup = 1'b1;
              st_nxt  = ST_OLD_DUP;
              drop    = 1'b1;
            end else if (rtx_en_r && !seq_before(seq_q_r, right_e)) begin
              st_nxt = ST_OUT_WIN;
              drop   = 1'b1;
            end else if (rtx_en_r && !seq_before(seq_q_r, left_e + QD32)) begin
              st_nxt = ST_OUT_QUEUE;
              drop   = 1'b1;
            end else if (rtx_en_r && valid_q_r) begin
              st_nxt = ST_QUEUE_DUP;
              drop   = 1'b1;
            end else begin
              if (rtx_en_r) aat_nxt = 1'b1;
              else rle_nxt = seq_q_r;
              queue_wr    = 1'b1;
              rcv_sec_nxt = {1'b0, sec_q_r};
              rcv_ns_nxt  = ns_q_r;
              st_nxt      = ST_QUEUED;
            end
          end
          // delayed ack on a dropped header
          want_ack = drop && ack_time_ok &&
                     seq_before(old_dup ? seq_q_r : rla_r, left_e);
          if (want_ack) begin
            rla_nxt = left_e;
            fl_nxt  = FL_ACK_WIN;
            ak_nxt  = left_e;
            wn_nxt  = right_e[23:0];
          end
        end
        CMD_SEND: begin
          if (snext_r == sle_r) sflags = sflags | FL_RUN;
          sre_nxt = sre_base;
          if (rfresh_r) begin
            sflags = sflags | FL_WIN;
            wn_nxt = rre_r[23:0];
          end
          if (!rtx_en_r) begin
            sle_nxt = sle_base + 32'd1;
          end else begin
            sle_nxt = sle_base;
            if (!probe_act_r) begin
              probe_seq_nxt = s_base;
              probe_ns_nxt  = ns_q_r;
              probe_act_nxt = 1'b1;
            end
            if (rack_ok) begin
              sflags  = sflags | FL_ACK;
              ak_nxt  = rle_r;
              rla_nxt = rle_r;
            end
            art_nxt = 1'b1;
          end
          snext_nxt   = s_base + 32'd1;
          snd_act_nxt = {1'b0, sec_q_r};
          st_nxt      = ST_SENT;
          fl_nxt      = sflags;
          sq_nxt      = s_base;
        end
        CMD_DEQUEUE: begin
          if (valid_q_r) begin
            st_nxt  = ST_DEQUEUED;
            hd_nxt  = mem_q_r;
            deq_clr = 1'b1;
            rle_nxt = rle_r + 32'd1;
            rre_nxt = rre_r + 32'd1;
          end else begin
            st_nxt = ST_EMPTY;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sle_r       <= '0;
      sre_r       <= {8'b0, RST_START_WIN};
      snext_r     <= '0;
      snd_act_r   <= {1'b1, 32'b0};
      rle_r       <= '0;
      rre_r       <= '0;
      rla_r       <= '0;
      rcv_sec_r   <= {1'b1, 32'b0};
      rcv_ns_r    <= '0;
      rto_r       <= RST_RTO;
      probe_seq_r <= '0;
      probe_ns_r  <= '0;
      probe_act_r <= 1'b0;
      win_open_r  <= 1'b0;
      valid_r     <= '0;
    end else begin
      sle_r       <= sle_nxt;
      sre_r       <= sre_nxt;
      snext_r     <= snext_nxt;
      snd_act_r   <= snd_act_nxt;
      rle_r       <= rle_nxt;
      rre_r       <= rre_nxt;
      rla_r       <= rla_nxt;
      rcv_sec_r   <= rcv_sec_nxt;
      rcv_ns_r    <= rcv_ns_nxt;
      rto_r       <= rto_nxt;
      probe_seq_r <= probe_seq_nxt;
      probe_ns_r  <= probe_ns_nxt;
      probe_act_r <= probe_act_nxt;
      win_open_r  <= win_open_nxt;
      if (queue_wr) valid_r[rx_pos] <= 1'b1;
      if (deq_clr) valid_r[dq_pos] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.exec) begin
      out_status          <= st_nxt;
      out_ctrl_flags      <= fl_nxt;
      out_ctrl_seqno      <= sq_nxt;
      out_ctrl_ackno      <= ak_nxt;
      out_ctrl_window     <= wn_nxt;
      out_handle          <= hd_nxt;
      out_arm_ack_timer   <= aat_nxt;
      out_arm_retransmit  <= art_nxt;
      out_window_reopened <= reo_nxt;
    end
  end

endmodule

// ===== rtl/core/sliding_window_flow_retransmit_control_core.sv =====
`timescale 1ns / 1ps
// top level of the sliding window flow core: sequencer plus datapath
// depends on swfrc_pkg, swfrc_ctrl, swfrc_dp
//
// usage
//   command channel: drive in_* and raise start; the transfer happens at the
//   edge where start is high and busy is low. one command per transfer:
//   receive header, send data packet or dequeue next in order
//   result channel: out_valid strobes for exactly one cycle with the status
//   and any control header to emit; the receiver cannot hold it off
//   config port: cfg_we with cfg_index and cfg_wdata writes one register at
//   the edge; write only while the block is idle, the block does not enforce it
// timing
//   the result strobe follows the execute step; when an ack ends an rtt probe,
//   four extra steps through the estimator come between prepare and execute
//   a new command is taken in the strobe cycle, so commands do not overlap;
//   an unknown command is dropped after the load step, with no result strobe
//   queue read uses one registered memory port, set up in the load cycle
// reset
//   synchronous active-low reset restores register defaults, clears the
//   flow state and all reorder queue valid bits at once, no clearing pass
module sliding_window_flow_retransmit_control_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_command,
  input  logic [31:0]                         in_now_sec,
  input  logic [62:0]                         in_now_ns,
  input  logic [6:0]                          in_pkt_flags,
  input  logic [31:0]                         in_pkt_seqno,
  input  logic [31:0]                         in_pkt_ackno,
  input  logic [23:0]                         in_pkt_window,
  input  logic [swfrc_pkg::HANDLE_BITS-1:0]   in_buffer_handle,
  input  logic [31:0]                         in_random_seed,
  // result channel
  output logic                                out_valid,
  output logic [3:0]                          out_status,
  output logic [6:0]                          out_ctrl_flags,
  output logic [31:0]                         out_ctrl_seqno,
  output logic [31:0]                         out_ctrl_ackno,
  output logic [23:0]                         out_ctrl_window,
  output logic [swfrc_pkg::HANDLE_BITS-1:0]   out_handle,
  output logic                                out_arm_ack_timer,
  output logic                                out_arm_retransmit,
  output logic                                out_window_reopened,
  // configuration
  input  logic                                cfg_we,
  input  logic [swfrc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [swfrc_pkg::CFG_W-1:0]         cfg_wdata
);
  import swfrc_pkg::*;

  // command and status between sequencer and datapath
  swfrc_cmd_t cmd;
  swfrc_sts_t sts;

  // sequencer: load, prepare, optional estimator steps, execute
  swfrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // datapath: flow state, queue, estimator, result registers
  swfrc_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_command          (in_command),
    .in_now_sec          (in_now_sec),
    .in_now_ns           (in_now_ns),
    .in_pkt_flags        (in_pkt_flags),
    .in_pkt_seqno        (in_pkt_seqno),
    .in_pkt_ackno        (in_pkt_ackno),
    .in_pkt_window       (in_pkt_window),
    .in_buffer_handle    (in_buffer_handle),
    .in_random_seed      (in_random_seed),
    .out_status          (out_status),
    .out_ctrl_flags      (out_ctrl_flags),
    .out_ctrl_seqno      (out_ctrl_seqno),
    .out_ctrl_ackno      (out_ctrl_ackno),
    .out_ctrl_window     (out_ctrl_window),
    .out_handle          (out_handle),
    .out_arm_ack_timer   (out_arm_ack_timer),
    .out_arm_retransmit  (out_arm_retransmit),
    .out_window_reopened (out_window_reopened)
  );

endmodule

// ===== rtl/core/swfrc_checker.sv =====
`timescale 1ns / 1ps
// port-level checks for the sliding window flow core, bound to the top level
// depends on swfrc_pkg and the core macros header
`include "sliding_window_flow_retransmit_control_core_macros.svh"

module swfrc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              out_valid,
  input logic [3:0]                        out_status,
  input logic [swfrc_pkg::HANDLE_BITS-1:0] out_handle,
  input logic                              out_arm_retransmit
);
  import swfrc_pkg::*;

  `SWFRC_ASSERT_NEXT(a_take_busy, start && !busy, busy, "no busy after command transfer")
  `SWFRC_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "result strobe longer than a cycle")
  `SWFRC_ASSERT_NOW(a_status_range, out_valid, out_status <= ST_EMPTY, "status code out of range")
  `SWFRC_ASSERT_NOW(a_handle_zero, out_valid && (out_status != ST_DEQUEUED), out_handle == '0, "handle on non-dequeue result")
  `SWFRC_ASSERT_NOW(a_rtx_only_send, out_valid && (out_status != ST_SENT), !out_arm_retransmit, "retransmit armed without send")

endmodule

bind sliding_window_flow_retransmit_control_core swfrc_checker u_swfrc_checker (.*);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for the sliding window flow core: directed and random commands
// with an in-bench flow predictor and an in-order result check
// depends on swfrc_pkg and sliding_window_flow_retransmit_control_core
module tb;
  import swfrc_pkg::*;

  localparam int WATCHDOG_LIMIT = 300;
  localparam int DRAIN_CYCLES   = 12;
  localparam longint MAX48      = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] sec;
    logic [62:0] ns;
    logic [6:0]  flags;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [23:0] win;
    logic [15:0] handle;
    logic [31:0] seed;
  } item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [6:0]  flags;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [23:0] win;
    logic [15:0] handle;
    logic        arm_ack;
    logic        arm_rtx;
    logic        reopen;
  } result_t;

  logic clk, rst_n, start, busy;
  logic [1:0]  in_command;
  logic [31:0] in_now_sec, in_pkt_seqno, in_pkt_ackno, in_random_seed;
  logic [62:0] in_now_ns;
  logic [6:0]  in_pkt_flags;
  logic [23:0] in_pkt_window;
  logic [HANDLE_BITS-1:0] in_buffer_handle;
  logic out_valid, out_arm_ack_timer, out_arm_retransmit, out_window_reopened;
  logic [3:0]  out_status;
  logic [6:0]  out_ctrl_flags;
  logic [31:0] out_ctrl_seqno, out_ctrl_ackno;
  logic [23:0] out_ctrl_window;
  logic [HANDLE_BITS-1:0] out_handle;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  sliding_window_flow_retransmit_control_core dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // flow predictor: register copies and per-flow state
  // ---------------------------------------------------------------------------
  logic [39:0] ack_delay;
  logic [15:0] snd_idle_lim, rcv_idle_lim;
  logic        rtx_en;
  logic [23:0] init_win;
  logic [31:0] rto_floor;

  logic [31:0] snd_lo, snd_hi, snd_nxt, snd_sec;
  logic        snd_seen;
  logic [31:0] rcv_lo, rcv_hi, rcv_acked, rcv_sec;
  logic        rcv_seen;
  logic [62:0] rcv_ns;
  logic [47:0] srtt, rttvar, rto;
  logic [31:0] probe_seq;
  logic [62:0] probe_ns;
  logic        probe_on, win_open;
  logic        rq_valid [QUEUE_DEPTH];
  logic [15:0] rq_handle [QUEUE_DEPTH];

  result_t pending_headers[$];
  int      n_errors, n_checked, n_accepted;
  bit      status_seen [16];
  int      idle_cycles;

  // stimulus time base
  logic [31:0] t_sec;
  logic [62:0] t_ns;
  bit          no_gaps;

  function automatic void flow_reset();
    ack_delay    = RST_ACK_DELAY;
    snd_idle_lim = RST_SEND_INACT;
    rcv_idle_lim = RST_RECV_INACT;
    rtx_en       = 1'b1;
    init_win     = RST_START_WIN;
    rto_floor    = RST_RTO_FLOOR;
    snd_lo = '0; snd_hi = 32'(RST_START_WIN); snd_nxt = '0; snd_sec = '0; snd_seen = 1'b0;
    rcv_lo = '0; rcv_hi = '0; rcv_acked = '0; rcv_sec = '0; rcv_seen = 1'b0; rcv_ns = '0;
    srtt = '0; rttvar = RST_DEV; rto = RST_RTO;
    probe_seq = '0; probe_ns = '0; probe_on = 1'b0; win_open = 1'b0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      rq_valid[i] = 1'b0;
      rq_handle[i] = '0;
    end
  endfunction

  // serial number order, a strictly earlier than b
  function automatic bit serial_lt(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  // signed shift rounding toward minus infinity
  function automatic longint floor_div_pow2(longint v, int s);
    if (v >= 0) return v >>> s;
    return -(((-v) + (64'sd1 <<< s) - 1) >>> s);
  endfunction

  function automatic void rtt_estimate(longint m);
    longint mr, s, v, d, ad, sum;
    mr = m < 0 ? 64'sd0 : (m > MAX48 ? MAX48 : m);
    s = longint'({16'd0, srtt});
    v = longint'({16'd0, rttvar});
    if (s == 0) begin
      s = mr;
      v = mr >>> 1;
    end else begin
      d = mr - s;
      ad = d < 0 ? -d : d;
      s += floor_div_pow2(d, 3);
      v += floor_div_pow2(ad - v, 2);
    end
    srtt = s < 1000 ? SRTT_MIN : s[47:0];
    rttvar = v < 100 ? DEV_MIN : v[47:0];
    sum = longint'({16'd0, srtt}) + (longint'({16'd0, rttvar}) <<< 2);
    if (sum > MAX48) sum = MAX48;
    rto = sum < longint'({32'd0, rto_floor}) ? 48'(rto_floor) : sum[47:0];
  endfunction

  // a dropped receive may still owe the peer an ack with the window
  function automatic result_t ack_on_drop(logic [62:0] ns, result_t r);
    longint diff;
    if (!serial_lt(rcv_acked, rcv_lo) || !rcv_seen) return r;
    diff = longint'({1'b0, ns}) - longint'({1'b0, rcv_ns});
    if (diff > longint'({24'd0, ack_delay}) || diff < longint'({16'd0, rttvar})) return r;
    rcv_acked = rcv_lo;
    r.flags = FL_ACK_WIN;
    r.ack = rcv_lo;
    r.win = rcv_hi[23:0];
    return r;
  endfunction

  function automatic bit flow_predict(input item_t it, output result_t r);
    bit rnever, drop;
    longint rsince;
    logic [QW-1:0] pos;
    logic [31:0] redge;
    logic [6:0] f;
    r = '0;
    rnever = !rcv_seen;
    rsince = longint'({32'd0, it.sec}) - longint'({32'd0, rcv_sec});
    case (it.cmd)
      CMD_RECEIVE: begin
        pos = it.seq[QW-1:0];
        drop = 1'b0;
        if (rnever || rsince > longint'({48'd0, rcv_idle_lim})) begin
          if (it.flags[FB_RUN]) begin
            rcv_lo = it.seq;
            rcv_hi = it.seq + QD32;
          end else begin
            r.status = ST_NO_RUN;
            drop = 1'b1;
          end
        end
        if (!drop) begin
          if (it.flags[FB_RDV]) begin
            r.status = ST_RDV;
            r.flags = FL_WIN;
            r.win = rcv_hi[23:0];
            return 1'b1;
          end
          if (it.flags[FB_ACK]) begin
            if (serial_lt(snd_lo, it.ack)) snd_lo = it.ack;
            if (probe_on && serial_lt(probe_seq, it.ack)) begin
              rtt_estimate(longint'({1'b0, it.ns}) - longint'({1'b0, probe_ns}));
              probe_on = 1'b0;
            end
          end
          if (it.flags[FB_WIN]) begin
            // rebuild the 32-bit edge from 24 bits, carrying on rollover
            redge = (snd_hi & WIN_HI_MASK) | {8'd0, it.win};
            if (serial_lt(redge, snd_hi) && (snd_hi - redge) > WIN_HALF) redge += WIN_CARRY;
            snd_hi = redge;
            if (!win_open) begin
              win_open = 1'b1;
              r.reopen = 1'b1;
            end
          end
          if (!it.flags[FB_DATA]) begin
            r.status = ST_CTRL_ONLY;
            drop = 1'b1;
          end else if (serial_lt(it.seq, rcv_lo)) begin
            rcv_acked = it.seq;
            r.status = ST_OLD_DUP;
            drop = 1'b1;
          end else if (rtx_en && !serial_lt(it.seq, rcv_hi)) begin
            r.status = ST_OUT_WIN;
            drop = 1'b1;
          end else if (rtx_en && !serial_lt(it.seq, rcv_lo + QD32)) begin
            r.status = ST_OUT_QUEUE;
            drop = 1'b1;
          end else if (rtx_en && rq_valid[pos]) begin
            r.status = ST_QUEUE_DUP;
            drop = 1'b1;
          end else begin
            if (rtx_en) r.arm_ack = 1'b1;
            else rcv_lo = it.seq;
            rq_valid[pos] = 1'b1;
            rq_handle[pos] = it.handle;
            rcv_seen = 1'b1;
            rcv_sec = it.sec;
            rcv_ns = it.ns;
            r.status = ST_QUEUED;
          end
        end
        if (drop) r = ack_on_drop(it.ns, r);
        return 1'b1;
      end
      CMD_SEND: begin
        f = FL_DATA;
        if (snd_nxt == snd_lo) f |= FL_RUN;
        if (!snd_seen || longint'({32'd0, it.sec}) - longint'({32'd0, snd_sec}) >
                         longint'({48'd0, snd_idle_lim})) begin
          snd_nxt = it.seed;
          snd_lo = snd_nxt;
          snd_hi = snd_lo + {8'd0, init_win};
        end
        r.seq = snd_nxt;
        if (!rnever && rsince < longint'({48'd0, rcv_idle_lim})) begin
          f |= FL_WIN;
          r.win = rcv_hi[23:0];
        end
        if (!rtx_en) begin
          snd_lo++;
        end else begin
          if (!probe_on) begin
            probe_seq = snd_nxt;
            probe_ns = it.ns;
            probe_on = 1'b1;
          end
          if (!rnever && rsince * 1000000000 <= longint'({24'd0, ack_delay})) begin
            f |= FL_ACK;
            r.ack = rcv_lo;
            rcv_acked = rcv_lo;
          end
          r.arm_rtx = 1'b1;
        end
        snd_nxt++;
        snd_seen = 1'b1;
        snd_sec = it.sec;
        r.status = ST_SENT;
        r.flags = f;
        return 1'b1;
      end
      CMD_DEQUEUE: begin
        pos = rcv_lo[QW-1:0];
        if (rq_valid[pos]) begin
          r.status = ST_DEQUEUED;
          r.handle = rq_handle[pos];
          rq_valid[pos] = 1'b0;
          rcv_lo++;
          rcv_hi++;
        end else begin
          r.status = ST_EMPTY;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // command side
  // ---------------------------------------------------------------------------
  // drive one command from the falling edge and hold it until the transfer;
  // start stays high so the next call can follow back to back
  task automatic send_command(input item_t it);
    result_t r;
    @(negedge clk);
    in_command = it.cmd;
    in_now_sec = it.sec;
    in_now_ns = it.ns;
    in_pkt_flags = it.flags;
    in_pkt_seqno = it.seq;
    in_pkt_ackno = it.ack;
    in_pkt_window = it.win;
    in_buffer_handle = it.handle;
    in_random_seed = it.seed;
    start = 1'b1;
    do @(posedge clk); while (busy);
    n_accepted++;
    if (flow_predict(it, r)) pending_headers.push_back(r);
  endtask

  task automatic sender_gap(input int cycles);
    @(negedge clk);
    start = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // config writes only once the block has gone quiet
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    start = 1'b0;
    while (pending_headers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(posedge clk);
    case (idx)
      REG_ACK_DELAY:  ack_delay = val[39:0];
      REG_SEND_INACT: snd_idle_lim = val[15:0];
      REG_RECV_INACT: rcv_idle_lim = val[15:0];
      REG_RTX_EN:     rtx_en = val[0];
      REG_START_WIN:  init_win = val[23:0];
      REG_RTO_FLOOR:  rto_floor = val[31:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic void advance_clock();
    int p;
    p = $urandom_range(0, 99);
    if (p < 3) t_ns -= 63'($urandom_range(1, 10000000));
    else t_ns += 63'($urandom_range(100000, 50000000));
    p = $urandom_range(0, 99);
    if (p < 8) t_sec += 1;
    else if (p < 10) t_sec += $urandom_range(32, 45);
    else if (p < 11) t_sec -= $urandom_range(1, 3);
  endfunction

  function automatic item_t make_item(logic [1:0] cmd, logic [6:0] flags, logic [31:0] seq,
                                      logic [31:0] ack, logic [23:0] win, logic [15:0] handle);
    item_t it;
    it = '{cmd: cmd, sec: t_sec, ns: t_ns, flags: flags, seq: seq, ack: ack, win: win,
           handle: handle, seed: $urandom};
    t_ns += 63'd20000000;
    return it;
  endfunction

  function automatic item_t random_item();
    item_t it;
    int p, q;
    bit need_run;
    advance_clock();
    it = '{cmd: CMD_RECEIVE, sec: t_sec, ns: t_ns, flags: 7'($urandom), seq: $urandom,
           ack: $urandom, win: 24'($urandom), handle: 16'($urandom), seed: $urandom};
    p = $urandom_range(0, 99);
    if (p >= 99) it.cmd = CMD_UNUSED;
    else if (p >= 70) it.cmd = CMD_DEQUEUE;
    else if (p >= 46) it.cmd = CMD_SEND;
    else if ($urandom_range(0, 99) < 85) begin
      // well-formed header from a peer that tracks our state
      need_run = !rcv_seen || (longint'({32'd0, t_sec}) - longint'({32'd0, rcv_sec}) >
                               longint'({48'd0, rcv_idle_lim}));
      it.flags = FL_DATA;
      if ($urandom_range(0, 99) < 60) it.flags |= FL_ACK;
      if ($urandom_range(0, 99) < 40) it.flags |= FL_WIN;
      if ($urandom_range(0, 99) < (need_run ? 85 : 10)) it.flags |= FL_RUN;
      if ($urandom_range(0, 99) < 10) it.flags[FB_DATA] = 1'b0;
      if ($urandom_range(0, 99) < 3) it.flags[FB_RDV] = 1'b1;
      q = $urandom_range(0, 99);
      if (q < 70) it.seq = rcv_lo + $urandom_range(0, 40);
      else if (q < 80) it.seq = rcv_lo - $urandom_range(1, 5);
      else if (q < 90) it.seq = rcv_lo + $urandom_range(200, 320);
      it.ack = snd_nxt - $urandom_range(0, 3);
      if ($urandom_range(0, 99) < 90) it.win = snd_hi[23:0] + 24'($urandom_range(0, 64)) - 24'd8;
    end
    return it;
  endfunction

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_command(random_item());
      if (!no_gaps && $urandom_range(0, 99) < 25) sender_gap($urandom_range(1, 6));
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_receive_paths();
    logic [31:0] s0;
    t_sec = '0;
    t_ns = '0;
    s0 = 32'hFFFF_FFFE;
    send_command(make_item(CMD_RECEIVE, FL_DATA, 32'd5, '0, '0, 16'h1234));      // no run
    send_command(make_item(CMD_DEQUEUE, '0, '0, '0, '0, '0));                    // empty
    send_command(make_item(CMD_SEND, '0, '0, '0, '0, '0));                       // new send run
    send_command(make_item(CMD_RECEIVE, FL_DATA | FL_RUN, s0, '0, '0, 16'hFFFF)); // queued
    send_command(make_item(CMD_RECEIVE, FL_DATA, s0, '0, '0, 16'h0001));          // queued dup
    send_command(make_item(CMD_RECEIVE, FL_DATA, s0 + 32'd300, '0, '0, '0));      // out of window
    send_command(make_item(CMD_RECEIVE, FL_DATA, s0 - 32'd1, '0, '0, '0));        // old duplicate
    send_command(make_item(CMD_RECEIVE, 7'h10, s0, '0, '0, '0));                  // rendezvous
    // ack ends the rtt probe, window wraps in its low 24 bits
    send_command(make_item(CMD_RECEIVE, FL_ACK_WIN, s0, snd_nxt,
                           snd_hi[23:0] - 24'h90_0000, '0));
    send_command(make_item(CMD_RECEIVE, FL_WIN, s0, '0, snd_hi[23:0] + 24'h80_0000, '0));
    send_command(make_item(CMD_DEQUEUE, '0, '0, '0, '0, '0));                    // dequeued
    send_command(make_item(CMD_DEQUEUE, '0, '0, '0, '0, '0));                    // empty
    send_command(make_item(CMD_RECEIVE, FL_ACK, s0, snd_nxt, '0, '0));           // ack emitted
    send_command(make_item(CMD_SEND, '0, '0, '0, '0, '0));                       // piggyback
    send_command(make_item(CMD_UNUSED, 7'h7F, '1, '1, '1, '1));                  // ignored
    send_command(make_item(CMD_RECEIVE, 7'h7F, '1, '1, '1, '1));                 // all ones
    send_command(make_item(CMD_RECEIVE, 7'h60, '0, '0, '0, '0));                 // top flag bits
  endtask

  // plain sequencing lets the left edge jump half the sequence space, which
  // leaves a right edge far ahead: reliable mode then sees out of queue
  task automatic test_out_of_queue();
    write_reg(REG_RTX_EN, '0);
    send_command(make_item(CMD_RECEIVE, FL_DATA, rcv_lo + 32'h7FFF_FFFF, '0, '0, 16'h00AA));
    write_reg(REG_RTX_EN, 40'd1);
    send_command(make_item(CMD_RECEIVE, FL_DATA, rcv_lo + 32'd300, '0, '0, '0));
    send_command(make_item(CMD_RECEIVE, FL_DATA, rcv_lo + 32'd1, '0, '0, '0));
  endtask

  task automatic test_random_phases();
    logic [CFG_W-1:0] regs [6];
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: regs = '{RST_ACK_DELAY, RST_SEND_INACT, RST_RECV_INACT, 1, RST_START_WIN,
                    RST_RTO_FLOOR};
        1: regs = '{0, 1, 1, 0, 1, 0};
        2: regs = '{40'd1000000000000, 16'hFFFF, 16'hFFFF, 1, 24'hFF_FFFF, 32'hFFFF_FFFF};
        3: regs = '{40'($urandom_range(1000000, 400000000)), $urandom_range(2, 60),
                    $urandom_range(2, 60), 1, $urandom_range(1, 4096), $urandom};
        default: regs = '{200000000, 5, 5, 1, 256, 250000};
      endcase
      for (int k = 0; k < 6; k++) write_reg(CFG_IDX_W'(k), regs[k]);
      // fresh time base per phase so every time bit moves, one phase near the top
      t_sec = ph == 2 ? 32'hFFFF_FFF0 : $urandom;
      t_ns = ph == 2 ? 63'h7FFF_FFFF_FF00_0000 : {$urandom, $urandom};
      no_gaps = ph == 2;
      run_random(186);
    end
    no_gaps = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // result check: every strobe against the oldest expected header
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_valid) begin
      got = '{out_status, out_ctrl_flags, out_ctrl_seqno, out_ctrl_ackno, out_ctrl_window,
              out_handle, out_arm_ack_timer, out_arm_retransmit, out_window_reopened};
      if (pending_headers.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result transfer %p", got);
      end else begin
        want = pending_headers.pop_front();
        n_checked++;
        status_seen[want.status] = 1'b1;
        if (got !== want) begin
          n_errors++;
          if (n_errors <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[sliding_window_flow_retransmit_control_core] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int n_codes;
    rst_n = 1'b0;
    start = 1'b0;
    in_command = '0; in_now_sec = '0; in_now_ns = '0; in_pkt_flags = '0;
    in_pkt_seqno = '0; in_pkt_ackno = '0; in_pkt_window = '0;
    in_buffer_handle = '0; in_random_seed = '0;
    cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    n_errors = 0; n_checked = 0; n_accepted = 0; idle_cycles = 0; no_gaps = 1'b0;
    flow_reset();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_receive_paths();
    test_out_of_queue();
    test_random_phases();

    sender_gap(0);
    while (pending_headers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    n_codes = 0;
    for (int i = 0; i < 16; i++) n_codes += status_seen[i];
    $display("%0d commands sent over six register settings, %0d results checked,",
             n_accepted, n_checked);
    $display("%0d distinct status codes seen, %0d mismatches", n_codes, n_errors);
    if (n_errors == 0) begin
      $display("[sliding_window_flow_retransmit_control_core] OK");
    end else begin
      $display("[sliding_window_flow_retransmit_control_core] ERROR");
    end
    $finish;
  end

endmodule
